>>> src/mpbs_pkg.sv
// Package for the multi-policy burst scheduler: sizes, item types, codes
// and small helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpbs_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_THREADS = 16;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int THR_IDX_W   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int VR_W        = 64;
	localparam int WGT_W       = 7;
	localparam int PROD_W      = 24 + WGT_W;

	localparam logic [1:0] STAT_ENQ   = 2'd0;
	localparam logic [1:0] STAT_DISP  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_DROP  = 2'd3;

	typedef enum logic [1:0] {
		POL_FCFS = 2'd0,
		POL_SJF  = 2'd1,
		POL_PRIO = 2'd2,
		POL_VRT  = 2'd3
	} policy_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_VR_RD,
		S_VR_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [4:0]  thread;
		logic [23:0] length;
		logic [31:0] arrival;
	} entry_t;

	typedef struct packed {
		logic        operation;
		logic [4:0]  thread_id;
		logic [23:0] burst_length;
		logic [31:0] timestamp;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  chosen_thread;
		logic [23:0] chosen_length;
		logic [31:0] chosen_arrival;
		logic [31:0] wait_time;
		logic [6:0]  queue_count;
	} out_t;

	// one scanned entry handed to the selection stage
	typedef struct packed {
		logic              vld;
		logic              first;
		logic [QIDX_W-1:0] idx;
		entry_t            ent;
		logic [VR_W-1:0]   vr;
	} pick_req_t;

	function automatic logic [THR_IDX_W-1:0] thr_addr(input logic [4:0] thread);
		logic [THR_IDX_W+4:0] t;
		t = (THR_IDX_W + 5)'(thread) - (THR_IDX_W + 5)'(1);
		return t[THR_IDX_W-1:0];
	endfunction

	function automatic logic [WGT_W-1:0] weight(input logic [4:0] thread);
		return WGT_W'(7) + WGT_W'(3) * WGT_W'(thread);
	endfunction

endpackage
`default_nettype wire

>>> src/multi_policy_burst_scheduler_top.sv
// Top level of the multi-policy burst scheduler: sequencer, run-queue RAM
// and virtual-runtime RAM. Depends on mpbs_pkg, mpbs_ram, mpbs_pick.
//
// Usage: input items (in_valid/in_ready, in_data) either append a burst or
// dispatch one; each gives exactly one result item on out_valid/out_ready.
// cfg_we/cfg_wdata write policy_mode; the user keeps that to idle, unchecked.
// in_ready is high only while the sequencer is idle; one item is in work.
// Enqueue, drop and empty-dispatch items go straight to loading the result;
// the next item is taken once the result is loaded.
// A dispatch over the queued bursts runs a scan (one queue RAM read per
// cycle, then one vruntime RAM read behind it), a compaction of the
// entries behind the pick (read one entry, write it one place down), a
// vruntime read and write in the virtual-runtime policy, and a load of
// the result.
// Reset empties the queue, clears all virtual runtimes (valid bits) and
// selects first come first served. A result waits in the output register
// while the receiver stalls; a new item is still taken meanwhile, and the
// sequencer holds its next result until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module multi_policy_burst_scheduler_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mpbs_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mpbs_pkg::out_t      out_data,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_wdata
);

	mpbs_pkg::state_t                 state_q, state_d;
	mpbs_pkg::policy_t                mode_q;
	mpbs_pkg::in_t                    req_q;
	logic [1:0]                       status_q;
	logic [mpbs_pkg::CNT_W-1:0]       count_q;
	logic [mpbs_pkg::CNT_W-1:0]       rd_idx_q;
	logic                             valid_s1, valid_s2;
	logic [mpbs_pkg::QIDX_W-1:0]      idx_s1, idx_s2;
	mpbs_pkg::entry_t                 ent_s2;
	logic                             vr_vld_s2;
	logic [mpbs_pkg::MAX_THREADS-1:0] vr_vld_q;
	logic [mpbs_pkg::PROD_W-1:0]      prod_q;
	logic                             out_valid_q;
	mpbs_pkg::out_t                   out_q;

	logic                             accept, drop, rd_issue, scan_done, shift_done, out_load;
	logic                             q_we;
	logic [mpbs_pkg::QIDX_W-1:0]      q_waddr, q_raddr;
	mpbs_pkg::entry_t                 q_wdata, q_rdata, new_ent;
	logic                             vr_we;
	logic [mpbs_pkg::THR_IDX_W-1:0]   vr_raddr, vr_waddr;
	logic [mpbs_pkg::VR_W-1:0]        vr_rdata, vr_cur;
	mpbs_pkg::pick_req_t              pick_req;
	logic [mpbs_pkg::QIDX_W-1:0]      best_idx;
	mpbs_pkg::entry_t                 best_ent;

	assign in_ready  = (state_q == mpbs_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign drop      = (count_q >= mpbs_pkg::CNT_W'(mpbs_pkg::QUEUE_DEPTH))
		|| (in_data.thread_id == 5'd0)
		|| (32'(in_data.thread_id) > 32'(mpbs_pkg::MAX_THREADS));
	assign rd_issue  = ((state_q == mpbs_pkg::S_SCAN) || (state_q == mpbs_pkg::S_SHIFT))
		&& (rd_idx_q < count_q);
	assign scan_done  = (rd_idx_q == count_q) && !valid_s1 && !valid_s2;
	assign shift_done = (rd_idx_q == count_q) && !valid_s1;
	assign out_load   = (state_q == mpbs_pkg::S_DONE) && (!out_valid_q || out_ready);

	assign new_ent.thread  = in_data.thread_id;
	assign new_ent.length  = in_data.burst_length;
	assign new_ent.arrival = in_data.timestamp;

	// queue RAM ports: enqueue write in idle, compaction write one place down
	always_comb begin
		q_we    = 1'b0;
		q_waddr = count_q[mpbs_pkg::QIDX_W-1:0];
		q_wdata = new_ent;
		if (accept && !in_data.operation && !drop) begin
			q_we = 1'b1;
		end else if ((state_q == mpbs_pkg::S_SHIFT) && valid_s1) begin
			q_we    = 1'b1;
			q_waddr = idx_s1 - mpbs_pkg::QIDX_W'(1);
			q_wdata = q_rdata;
		end
	end
	assign q_raddr = rd_idx_q[mpbs_pkg::QIDX_W-1:0];

	mpbs_ram #(
		.WIDTH($bits(mpbs_pkg::entry_t)),
		.DEPTH(mpbs_pkg::QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign vr_raddr = (state_q == mpbs_pkg::S_VR_RD) ? mpbs_pkg::thr_addr(best_ent.thread)
		: mpbs_pkg::thr_addr(q_rdata.thread);
	assign vr_cur   = vr_vld_s2 ? vr_rdata : '0;
	assign vr_we    = (state_q == mpbs_pkg::S_VR_WR);
	assign vr_waddr = mpbs_pkg::thr_addr(best_ent.thread);

	mpbs_ram #(
		.WIDTH(mpbs_pkg::VR_W),
		.DEPTH(mpbs_pkg::MAX_THREADS)
	) u_vr_ram (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_waddr),
		.wdata (vr_cur + mpbs_pkg::VR_W'(prod_q)),
		.raddr (vr_raddr),
		.rdata (vr_rdata)
	);

	assign pick_req.vld   = valid_s2;
	assign pick_req.first = (idx_s2 == '0);
	assign pick_req.idx   = idx_s2;
	assign pick_req.ent   = ent_s2;
	assign pick_req.vr    = vr_cur;

	mpbs_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.req      (pick_req),
		.best_idx (best_idx),
		.best_ent (best_ent)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpbs_pkg::S_IDLE: begin
				if (accept) begin
					if (in_data.operation && (count_q != '0)) begin
						state_d = mpbs_pkg::S_SCAN;
					end else begin
						state_d = mpbs_pkg::S_DONE;
					end
				end
			end
			mpbs_pkg::S_SCAN: begin
				if (scan_done) begin
					state_d = mpbs_pkg::S_SHIFT;
				end
			end
			mpbs_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = (mode_q == mpbs_pkg::POL_VRT) ? mpbs_pkg::S_VR_RD
						: mpbs_pkg::S_DONE;
				end
			end
			mpbs_pkg::S_VR_RD: state_d = mpbs_pkg::S_VR_WR;
			mpbs_pkg::S_VR_WR: state_d = mpbs_pkg::S_DONE;
			mpbs_pkg::S_DONE: begin
				if (out_load) begin
					state_d = mpbs_pkg::S_IDLE;
				end
			end
			default: state_d = mpbs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpbs_pkg::S_IDLE;
			mode_q      <= mpbs_pkg::POL_FCFS;
			count_q     <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			vr_vld_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_issue;
			valid_s2 <= (state_q == mpbs_pkg::S_SCAN) && valid_s1;
			if (cfg_we) begin
				mode_q <= mpbs_pkg::policy_t'(cfg_wdata);
			end
			if (accept && !in_data.operation && !drop) begin
				count_q <= count_q + mpbs_pkg::CNT_W'(1);
			end else if ((state_q == mpbs_pkg::S_SHIFT) && shift_done) begin
				count_q <= count_q - mpbs_pkg::CNT_W'(1);
			end
			if (accept) begin
				rd_idx_q <= '0;
			end else if ((state_q == mpbs_pkg::S_SCAN) && scan_done) begin
				rd_idx_q <= mpbs_pkg::CNT_W'(best_idx) + mpbs_pkg::CNT_W'(1);
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + mpbs_pkg::CNT_W'(1);
			end
			if (vr_we) begin
				vr_vld_q[vr_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= rd_idx_q[mpbs_pkg::QIDX_W-1:0];
		idx_s2    <= idx_s1;
		ent_s2    <= q_rdata;
		vr_vld_s2 <= vr_vld_q[vr_raddr];
		if (accept) begin
			req_q <= in_data;
			if (!in_data.operation) begin
				status_q <= drop ? mpbs_pkg::STAT_DROP : mpbs_pkg::STAT_ENQ;
			end else begin
				status_q <= (count_q == '0) ? mpbs_pkg::STAT_EMPTY : mpbs_pkg::STAT_DISP;
			end
		end
		if (state_q == mpbs_pkg::S_VR_RD) begin
			prod_q <= mpbs_pkg::PROD_W'(best_ent.length)
				* mpbs_pkg::PROD_W'(mpbs_pkg::weight(best_ent.thread));
		end
		if (out_load) begin
			out_q.status      <= status_q;
			out_q.queue_count <= 7'(count_q);
			if (status_q == mpbs_pkg::STAT_DISP) begin
				out_q.chosen_thread  <= best_ent.thread;
				out_q.chosen_length  <= best_ent.length;
				out_q.chosen_arrival <= best_ent.arrival;
				out_q.wait_time      <= req_q.timestamp - best_ent.arrival;
			end else begin
				out_q.chosen_thread  <= '0;
				out_q.chosen_length  <= '0;
				out_q.chosen_arrival <= '0;
				out_q.wait_time      <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mpbs_pkg::CNT_W'(mpbs_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_data.operation && !drop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("enqueue did not grow the queue");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mpbs_pkg::S_SHIFT) && valid_s1) |->
		(mpbs_pkg::CNT_W'(idx_s1) < count_q) && (idx_s1 != '0))
		else $error("compaction write outside queue");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpbs_pkg::S_IDLE) |-> (!valid_s1 && !valid_s2))
		else $error("scan pipeline busy while idle");
`endif

endmodule
`default_nettype wire

>>> src/mpbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mpbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/mpbs_pick.sv
// Selection stage: keeps the best entry so far and the per-thread seen mask
// while the queue is scanned in order. Depends on mpbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpbs_pick (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mpbs_pkg::policy_t            mode,
	input  wire mpbs_pkg::pick_req_t          req,
	output logic [mpbs_pkg::QIDX_W-1:0]       best_idx,
	output mpbs_pkg::entry_t                  best_ent
);

	logic [mpbs_pkg::MAX_THREADS-1:0] seen_q;
	logic [mpbs_pkg::QIDX_W-1:0]      best_idx_q;
	mpbs_pkg::entry_t                 best_ent_q;
	logic [mpbs_pkg::VR_W-1:0]        best_vr_q;
	logic [mpbs_pkg::THR_IDX_W-1:0]   a;
	logic                             is_first;
	logic                             take;

	always_comb begin
		a        = mpbs_pkg::thr_addr(req.ent.thread);
		is_first = !seen_q[a];
		case (mode)
			mpbs_pkg::POL_FCFS: take = req.ent.arrival < best_ent_q.arrival;
			mpbs_pkg::POL_SJF:  take = is_first && (req.ent.length < best_ent_q.length);
			mpbs_pkg::POL_PRIO: take = req.ent.thread < best_ent_q.thread;
			mpbs_pkg::POL_VRT:  take = is_first && (req.vr < best_vr_q);
			default:            take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (req.vld) begin
			if (req.first) begin
				seen_q <= mpbs_pkg::MAX_THREADS'(1) << a;
			end else begin
				seen_q[a] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld && (req.first || take)) begin
			best_idx_q <= req.idx;
			best_ent_q <= req.ent;
			best_vr_q  <= req.vr;
		end
	end

	assign best_idx = best_idx_q;
	assign best_ent = best_ent_q;

endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for multi_policy_burst_scheduler_top: random and directed
// enqueue/dispatch items checked against a run-queue predictor.
// Depends on mpbs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

class sched_scoreboard;
	mpbs_pkg::out_t due_q[$];
	logic [4:0]  q_thr[$];
	logic [23:0] q_len[$];
	logic [31:0] q_arr[$];
	logic [63:0] vrun[16];
	logic [1:0]  mode;
	int          errors;

	function void clear();
		q_thr.delete(); q_len.delete(); q_arr.delete(); due_q.delete();
		foreach (vrun[i]) vrun[i] = '0;
		mode = mpbs_pkg::POL_FCFS;
		errors = 0;
	endfunction

	// works out the result of one accepted item and queues it
	function void note_item(mpbs_pkg::in_t it);
		mpbs_pkg::out_t r;
		int best;
		logic [16:0] seen;
		logic first;
		r = '0;
		if (it.operation == 1'b0) begin
			if (q_thr.size() >= 64 || it.thread_id == 0 || it.thread_id > 16) begin
				r.status = mpbs_pkg::STAT_DROP;
			end else begin
				q_thr.push_back(it.thread_id);
				q_len.push_back(it.burst_length);
				q_arr.push_back(it.timestamp);
				r.status = mpbs_pkg::STAT_ENQ;
			end
		end else if (q_thr.size() == 0) begin
			r.status = mpbs_pkg::STAT_EMPTY;
		end else begin
			best = 0;
			seen = '0;
			for (int i = 0; i < q_thr.size(); i++) begin
				first = !seen[q_thr[i]];
				seen[q_thr[i]] = 1'b1;
				case (mode)
				mpbs_pkg::POL_FCFS: if (q_arr[i] < q_arr[best]) best = i;
				mpbs_pkg::POL_SJF: if (first && q_len[i] < q_len[best]) best = i;
				mpbs_pkg::POL_PRIO: if (q_thr[i] < q_thr[best]) best = i;
				default: if (first && vrun[q_thr[i]-1] < vrun[q_thr[best]-1]) best = i;
				endcase
			end
			r.status = mpbs_pkg::STAT_DISP;
			r.chosen_thread = q_thr[best];
			r.chosen_length = q_len[best];
			r.chosen_arrival = q_arr[best];
			r.wait_time = it.timestamp - q_arr[best];
			if (mode == mpbs_pkg::POL_VRT)
				vrun[q_thr[best]-1] += 64'(q_len[best]) * (64'd7 + 64'd3 * q_thr[best]);
			q_thr.delete(best); q_len.delete(best); q_arr.delete(best);
		end
		r.queue_count = 7'(q_thr.size());
		due_q.push_back(r);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task check_result(mpbs_pkg::out_t o);
		mpbs_pkg::out_t e;
		if (due_q.size() == 0) begin
			report("unexpected result", 64'(o.status), 64'd0);
			return;
		end
		e = due_q.pop_front();
		if (o.status != e.status) report("status", 64'(o.status), 64'(e.status));
		if (o.chosen_thread != e.chosen_thread)
			report("thread", 64'(o.chosen_thread), 64'(e.chosen_thread));
		if (o.chosen_length != e.chosen_length)
			report("length", 64'(o.chosen_length), 64'(e.chosen_length));
		if (o.chosen_arrival != e.chosen_arrival)
			report("arrival", 64'(o.chosen_arrival), 64'(e.chosen_arrival));
		if (o.wait_time != e.wait_time)
			report("wait", 64'(o.wait_time), 64'(e.wait_time));
		if (o.queue_count != e.queue_count)
			report("count", 64'(o.queue_count), 64'(e.queue_count));
	endtask
endclass

module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	mpbs_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mpbs_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic rx_hold = 1'b0;
	int burst_left = 0;
	sched_scoreboard sb;

	multi_policy_burst_scheduler_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: own stall pattern, long hold when asked
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
		out_ready <= !rx_hold && (($urandom_range(0, 3) != 0) || $urandom_range(0, 1));
	end

	// sender gap between bursts; valid drops only when a real gap follows
	task automatic gap();
		int n;
		if (burst_left == 0) begin
			n = $urandom_range(0, 6);
			if (n != 0) in_valid <= 1'b0;
			repeat (n) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// valid stays high after acceptance; the caller either sends again or idles
	task automatic send(mpbs_pkg::in_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic idle_in();
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		idle_in();
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	function automatic mpbs_pkg::in_t mk(logic op, logic [4:0] th, logic [23:0] len,
			logic [31:0] ts);
		mpbs_pkg::in_t it;
		it.operation = op; it.thread_id = th; it.burst_length = len; it.timestamp = ts;
		return it;
	endfunction

	// mostly valid threads, sometimes a bad one; lengths and stamps cluster for ties
	function automatic mpbs_pkg::in_t rand_item(int enq_bias);
		logic [4:0] th;
		logic [23:0] len;
		logic [31:0] ts;
		th = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(1, $urandom_range(0, 1) ? 4 : 16));
		len = $urandom_range(0, 1) ? 24'($urandom_range(0, 8)) : 24'($urandom);
		ts = $urandom_range(0, 1) ? 32'($urandom_range(0, 20)) : $urandom;
		return mk($urandom_range(0, 99) >= enq_bias, th, len, ts);
	endfunction

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty dispatch, bad threads, field extremes
		send(mk(1'b1, 5'd0, 24'd0, 32'd0));
		send(mk(1'b0, 5'd0, 24'd5, 32'd1));
		send(mk(1'b0, 5'd17, 24'd5, 32'd1));
		send(mk(1'b0, 5'd31, 24'hFFFFFF, 32'hFFFFFFFF));
		send(mk(1'b0, 5'd16, 24'hFFFFFF, 32'hFFFFFFFF));
		send(mk(1'b0, 5'd1, 24'd0, 32'd0));
		send(mk(1'b0, 5'd16, 24'd3, 32'd0));
		send(mk(1'b1, 5'd31, 24'hFFFFFF, 32'd5));
		send(mk(1'b1, 5'd0, 24'd0, 32'd0));
		send(mk(1'b1, 5'd0, 24'd0, 32'd0));
		send(mk(1'b1, 5'd0, 24'd0, 32'd0));
		// fill to full, then a dropped enqueue, then dispatches under each policy
		for (int i = 0; i < 65; i++) send(mk(1'b0, 5'($urandom_range(1, 16)),
			24'($urandom), $urandom));
		for (int m = 0; m < 4; m++) begin
			set_mode(2'(m));
			for (int i = 0; i < 16; i++) send(mk(1'b1, 5'd0, 24'd0, $urandom));
		end
		// random phases under random policies, the last in VRT for large runtimes
		for (int ph = 0; ph < 8; ph++) begin
			set_mode(2'(ph == 7 ? 3 : $urandom_range(0, 3)));
			for (int i = 0; i < 180; i++) begin
				gap();
				send(rand_item(ph == 2 ? 85 : 55));
				if (ph == 4 && i == 60) begin
					// long receiver hold while the sender keeps offering
					rx_hold <= 1'b1;
					fork
						begin repeat (300) @(posedge clk); rx_hold <= 1'b0; end
					join_none
				end
				if (ph == 5 && i == 90) begin
					idle_in();
					while (sb.due_q.size() != 0) @(posedge clk);
				end
			end
		end
		drain();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
